// ===== rtl/ntb_pkg.sv =====
// ----------------------------------------------------------------------------
// ntb_pkg
// Shared types and constants of the nearest target bearing block: angle
// formats, the CORDIC arctangent table and the controller/datapath links.
// ----------------------------------------------------------------------------
package ntb_pkg;

	localparam int DIST_W    = 49;
	localparam int ANG_W     = 20;
	localparam int TAB_LEN   = 24;
	localparam int TAB_IDX_W = 5;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// Q16 radians
	localparam logic signed [ANG_W-1:0] ANG_PI      = 20'sd205887;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 20'sd102944;

	// round(atan(2^-i) * 2^16)
	localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
		20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150,
		20'sd4091,  20'sd2047,  20'sd1024,  20'sd512,
		20'sd256,   20'sd128,   20'sd64,    20'sd32,
		20'sd16,    20'sd8,     20'sd4,     20'sd2,
		20'sd1,     20'sd0,     20'sd0,     20'sd0,
		20'sd0,     20'sd0,     20'sd0,     20'sd0
	};

	typedef struct packed {
		logic capture;      // latch offsets of the accepted beat
		logic sq_x;         // square dx
		logic sq_y;         // square dy
		logic compare;      // distance compare, best update, CORDIC init
		logic cordic_step;  // one CORDIC rotation
		logic emit;         // load result, close the scan
	} ntb_cmd_t;

	typedef struct packed {
		logic live;
		logic last;
		logic better;
		logic dx_zero;
		logic step_last;
	} ntb_stat_t;

endpackage

// ===== rtl/nearest_target_bearing_top.sv =====
// ----------------------------------------------------------------------------
// nearest_target_bearing_top
// Nearest live candidate of a scan and its bearing by CORDIC, one result per
// scan at the beat that carries last_entry.
// ----------------------------------------------------------------------------
// Timing: one beat at a time; a skipped beat goes through capture and the finish
//   state only, a live beat also through squaring and compare, and through the
//   iterative CORDIC rotation when it becomes the new best off the vertical axis.
// Output: out_valid rises once the closing beat reaches the finish state, later
//   while an unread result holds the output register.
// Reset (arst_n low): sequencer idle, no result pending, scan empty, held
//   bearing 0.
// ----------------------------------------------------------------------------
module nearest_target_bearing_top #(
	parameter int COORD_WIDTH  = 24,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [COORD_WIDTH-1:0]   own_x,
	input  logic signed [COORD_WIDTH-1:0]   own_y,
	input  logic signed [COORD_WIDTH-1:0]   target_x,
	input  logic signed [COORD_WIDTH-1:0]   target_y,
	input  logic                            target_live,
	input  logic                            last_entry,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [ntb_pkg::ANG_W-1:0] bearing,
	output logic                            target_found
);

	ntb_pkg::ntb_cmd_t  cmd;
	ntb_pkg::ntb_stat_t stat;

	ntb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ntb_datapath #(
		.COORD_WIDTH  (COORD_WIDTH),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.own_x        (own_x),
		.own_y        (own_y),
		.target_x     (target_x),
		.target_y     (target_y),
		.target_live  (target_live),
		.last_entry   (last_entry),
		.cmd          (cmd),
		.stat         (stat),
		.bearing      (bearing),
		.target_found (target_found)
	);

endmodule

// ===== rtl/ntb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ntb_ctrl
// Sequencer: accepts one beat, walks the datapath through squaring, compare
// and CORDIC, and hands the scan result to the output register.
// ----------------------------------------------------------------------------
module ntb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ntb_pkg::ntb_stat_t stat,
	output ntb_pkg::ntb_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SQX  = 6'b000010,
		ST_SQY  = 6'b000100,
		ST_CMP  = 6'b001000,
		ST_CORD = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_SQX;
				end
			end
			ST_SQX: begin
				if (stat.live) begin
					cmd.sq_x = 1'b1;
					state_d  = ST_SQY;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_SQY: begin
				cmd.sq_y = 1'b1;
				state_d  = ST_CMP;
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				state_d     = (stat.better && !stat.dx_zero) ? ST_CORD : ST_FIN;
			end
			ST_CORD: begin
				cmd.cordic_step = 1'b1;
				if (stat.step_last) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!stat.last) begin
					state_d = ST_IDLE;
				end else if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ntb_ctrl: new beat taken while busy");

	a_emit_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.last && slot_free)
		else $error("ntb_ctrl: result emitted on non-last beat or full slot");

	a_cordic_exit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cordic_step && stat.step_last |=> state_q == ST_FIN)
		else $error("ntb_ctrl: CORDIC did not finish after last step");

endmodule

// ===== rtl/ntb_datapath.sv =====
// ----------------------------------------------------------------------------
// ntb_datapath
// Offsets, shared squaring multiplier, saturating distance compare, the
// best-candidate registers, an iterative CORDIC and the result register.
// ----------------------------------------------------------------------------
module ntb_datapath #(
	parameter int COORD_WIDTH  = 24,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic signed [COORD_WIDTH-1:0]   own_x,
	input  logic signed [COORD_WIDTH-1:0]   own_y,
	input  logic signed [COORD_WIDTH-1:0]   target_x,
	input  logic signed [COORD_WIDTH-1:0]   target_y,
	input  logic                            target_live,
	input  logic                            last_entry,
	input  ntb_pkg::ntb_cmd_t               cmd,
	output ntb_pkg::ntb_stat_t              stat,
	output logic signed [ntb_pkg::ANG_W-1:0] bearing,
	output logic                            target_found
);

	localparam int DW     = COORD_WIDTH + 1;
	localparam int MAG_W  = COORD_WIDTH + 1;
	localparam int PROD_W = 2 * MAG_W;
	localparam int SQ_W   = (PROD_W > ntb_pkg::DIST_W) ? PROD_W : ntb_pkg::DIST_W + 1;
	localparam int XW     = COORD_WIDTH + 3;
	localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int DW_SUM = ntb_pkg::DIST_W + 1;

	logic signed [DW-1:0] dx_in, dy_in, dx_q, dy_q;
	logic                 live_q, last_q;

	logic signed [DW-1:0]          mag_sel;
	logic [MAG_W-1:0]              mag;
	logic [PROD_W-1:0]             prod;
	logic [SQ_W-1:0]               prod_ext;
	logic [ntb_pkg::DIST_W-1:0]    sq_sat;
	logic [ntb_pkg::DIST_W-1:0]    sqx_q, sqy_q;
	logic [DW_SUM-1:0]             dist_sum;
	logic [ntb_pkg::DIST_W-1:0]    dist_val;
	logic [ntb_pkg::DIST_W-1:0]    best_dist_q;
	logic                          have_best_q;
	logic signed [ntb_pkg::ANG_W-1:0] best_bearing_q, held_bearing_q;
	logic signed [ntb_pkg::ANG_W-1:0] special_ang;
	logic                          better;

	logic signed [XW-1:0]             x_q, y_q, xs, ys, x_next, y_next;
	logic signed [ntb_pkg::ANG_W-1:0] z_q, z_next, z_clamp, atan_val, base_ang;
	logic                             neg_q;
	logic [STEP_W-1:0]                step_q;
	logic [ntb_pkg::TAB_IDX_W-1:0]    tab_idx;

	assign dx_in = {target_x[COORD_WIDTH-1], target_x} - {own_x[COORD_WIDTH-1], own_x};
	assign dy_in = {target_y[COORD_WIDTH-1], target_y} - {own_y[COORD_WIDTH-1], own_y};

	// one multiplier, dx in one cycle and dy in the next
	assign mag_sel  = cmd.sq_x ? dx_q : dy_q;
	assign mag      = mag_sel[DW-1] ? $unsigned(~mag_sel + 1'b1) : $unsigned(mag_sel);
	assign prod     = mag * mag;
	assign prod_ext = SQ_W'(prod);
	assign sq_sat   = (prod_ext > SQ_W'(ntb_pkg::DIST_MAX)) ? ntb_pkg::DIST_MAX
	                                                         : prod_ext[ntb_pkg::DIST_W-1:0];

	assign dist_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign dist_val = dist_sum[ntb_pkg::DIST_W] ? ntb_pkg::DIST_MAX
	                                            : dist_sum[ntb_pkg::DIST_W-1:0];
	assign better   = !have_best_q || (dist_val < best_dist_q);

	always_comb begin
		if (dy_q > 0)      special_ang = ntb_pkg::ANG_HALF_PI;
		else if (dy_q < 0) special_ang = -ntb_pkg::ANG_HALF_PI;
		else               special_ang = '0;
	end

	// CORDIC vectoring, floor shifts
	assign tab_idx  = ntb_pkg::TAB_IDX_W'(step_q);
	assign atan_val = ntb_pkg::ATAN_TAB[tab_idx];
	assign xs       = x_q >>> step_q;
	assign ys       = y_q >>> step_q;

	always_comb begin
		if (!y_q[XW-1]) begin
			x_next = x_q + ys;
			y_next = y_q - xs;
			z_next = z_q + atan_val;
		end else begin
			x_next = x_q - ys;
			y_next = y_q + xs;
			z_next = z_q - atan_val;
		end
		if (z_next > ntb_pkg::ANG_HALF_PI)       z_clamp = ntb_pkg::ANG_HALF_PI;
		else if (z_next < -ntb_pkg::ANG_HALF_PI) z_clamp = -ntb_pkg::ANG_HALF_PI;
		else                                     z_clamp = z_next;
	end

	assign base_ang = neg_q ? ntb_pkg::ANG_PI : '0;

	assign stat.live      = live_q;
	assign stat.last      = last_q;
	assign stat.better    = better;
	assign stat.dx_zero   = (dx_q == '0);
	assign stat.step_last = (step_q == STEP_W'(CORDIC_STEPS - 1));

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dx_q   <= dx_in;
			dy_q   <= dy_in;
			live_q <= target_live;
			last_q <= last_entry;
		end
		if (cmd.sq_x) sqx_q <= sq_sat;
		if (cmd.sq_y) sqy_q <= sq_sat;
		if (cmd.compare) begin
			if (dx_q[DW-1]) begin
				x_q <= -XW'(dx_q);
				y_q <= -XW'(dy_q);
			end else begin
				x_q <= XW'(dx_q);
				y_q <= XW'(dy_q);
			end
			neg_q <= dx_q[DW-1];
			z_q   <= '0;
		end else if (cmd.cordic_step) begin
			x_q <= x_next;
			y_q <= y_next;
			z_q <= z_next;
		end
		if (cmd.compare && better) begin
			best_dist_q <= dist_val;
			if (dx_q == '0) best_bearing_q <= special_ang;
		end else if (cmd.cordic_step && stat.step_last) begin
			best_bearing_q <= base_ang + z_clamp;
		end else if (cmd.emit) begin
			best_dist_q <= '0;
		end
		if (cmd.emit) begin
			bearing      <= have_best_q ? best_bearing_q : held_bearing_q;
			target_found <= have_best_q;
		end
	end

	// scan control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q    <= 1'b0;
			held_bearing_q <= '0;
			step_q         <= '0;
		end else begin
			if (cmd.emit) begin
				have_best_q <= 1'b0;
				if (have_best_q) held_bearing_q <= best_bearing_q;
			end else if (cmd.compare && better) begin
				have_best_q <= 1'b1;
			end
			if (cmd.compare) step_q <= '0;
			else if (cmd.cordic_step) step_q <= step_q + 1'b1;
		end
	end

	a_emit_clears_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !have_best_q && target_found == $past(have_best_q))
		else $error("ntb_datapath: scan state not closed on emit");

	a_hold_tracks_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && have_best_q |=> held_bearing_q == bearing)
		else $error("ntb_datapath: held bearing differs from emitted bearing");

endmodule
